// ===== rtl/core/segi_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment intersection package
// Shared widths, status codes and the bundle that travels through the
// divider cell chain.
// ----------------------------------------------------------------------------
package segi_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned DiffW   = 17;
  localparam int unsigned CrossW  = 35;
  localparam int unsigned MagW    = 34;
  localparam int unsigned AlphaW  = 24;
  localparam int unsigned FracW   = 16;
  localparam int unsigned QuotW   = 51;
  localparam int unsigned RemW    = 35;
  localparam int unsigned HitMagW = 51;

  localparam int unsigned CellCount = QuotW;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_t;

  // One of the four divisions carried in a cell: dividend bits still to
  // be consumed, partial remainder, quotient built so far.
  typedef struct packed {
    logic [QuotW-1:0] dvd;
    logic [RemW-1:0]  rem;
    logic [QuotW-1:0] quo;
    logic             neg;
  } div_lane_t;

  typedef struct packed {
    logic                     vld;
    logic [MagW-1:0]          den;
    div_lane_t                la1;
    div_lane_t                la2;
    div_lane_t                lhx;
    div_lane_t                lhy;
    logic                     parallel;
    logic                     hit_ok;
    logic signed [CoordW-1:0] p1x;
    logic signed [CoordW-1:0] p1y;
  } cell_bus_t;

  function automatic logic signed [AlphaW-1:0] sat_alpha(input logic [QuotW-1:0] mag,
                                                         input logic neg);
    logic [QuotW:0] s;
    begin
      s = neg ? -{1'b0, mag} : {1'b0, mag};
      if (!neg && mag > QuotW'(23'h7fffff)) begin
        sat_alpha = 24'sh7fffff;
      end else if (neg && mag > QuotW'(24'h800000)) begin
        sat_alpha = -24'sh800000;
      end else begin
        sat_alpha = s[AlphaW-1:0];
      end
    end
  endfunction

endpackage

// ===== rtl/core/segment_intersection_unit.sv =====
// ----------------------------------------------------------------------------
// Segment intersection unit
// Takes one pair of Q8.8 segments a cycle and reports status, both
// parameters and the hit point.
// ----------------------------------------------------------------------------
// A pair is taken in every cycle that start is high; busy never rises. Each
// result appears on the out_ ports for a single cycle with out_valid, after
// passing the difference and cross-product registers of the front end, a chain
// of 51 divider cells that each yield one quotient bit, and the output register.
// The receiver must take every beat as it comes.
module segment_intersection_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [segi_pkg::CoordW-1:0] in_seg1_start_x,
  input  logic signed [segi_pkg::CoordW-1:0] in_seg1_start_y,
  input  logic signed [segi_pkg::CoordW-1:0] in_seg1_end_x,
  input  logic signed [segi_pkg::CoordW-1:0] in_seg1_end_y,
  input  logic signed [segi_pkg::CoordW-1:0] in_seg2_start_x,
  input  logic signed [segi_pkg::CoordW-1:0] in_seg2_start_y,
  input  logic signed [segi_pkg::CoordW-1:0] in_seg2_end_x,
  input  logic signed [segi_pkg::CoordW-1:0] in_seg2_end_y,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic signed [segi_pkg::AlphaW-1:0] out_alpha_one,
  output logic signed [segi_pkg::AlphaW-1:0] out_alpha_two,
  output logic signed [segi_pkg::CoordW-1:0] out_hit_x,
  output logic signed [segi_pkg::CoordW-1:0] out_hit_y
);

  segi_pkg::cell_bus_t chain [0:segi_pkg::CellCount];

  assign busy = 1'b0;

  segi_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start),
    .p1x     (in_seg1_start_x),
    .p1y     (in_seg1_start_y),
    .q1x     (in_seg1_end_x),
    .q1y     (in_seg1_end_y),
    .p2x     (in_seg2_start_x),
    .p2y     (in_seg2_start_y),
    .q2x     (in_seg2_end_x),
    .q2y     (in_seg2_end_y),
    .bus_out (chain[0])
  );

  for (genvar g = 0; g < segi_pkg::CellCount; g++) begin : g_cell
    segi_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .bus_in  (chain[g]),
      .bus_out (chain[g+1])
    );
  end

  segi_pkg::cell_bus_t tail;
  logic [segi_pkg::QuotW:0] hx_s, hy_s;
  logic signed [segi_pkg::CoordW-1:0] hx_nxt, hy_nxt;
  logic signed [segi_pkg::AlphaW-1:0] a1_nxt, a2_nxt;
  segi_pkg::status_t st_nxt;

  always_comb begin
    tail   = chain[segi_pkg::CellCount];
    hx_s   = tail.lhx.neg ? -{1'b0, tail.lhx.quo} : {1'b0, tail.lhx.quo};
    hy_s   = tail.lhy.neg ? -{1'b0, tail.lhy.quo} : {1'b0, tail.lhy.quo};
    a1_nxt = '0;
    a2_nxt = '0;
    hx_nxt = '0;
    hy_nxt = '0;
    if (tail.parallel) begin
      st_nxt = segi_pkg::ST_PARALLEL;
    end else begin
      a1_nxt = segi_pkg::sat_alpha(tail.la1.quo, tail.la1.neg);
      a2_nxt = segi_pkg::sat_alpha(tail.la2.quo, tail.la2.neg);
      if (tail.hit_ok) begin
        st_nxt = segi_pkg::ST_HIT;
        hx_nxt = tail.p1x + hx_s[segi_pkg::CoordW-1:0];
        hy_nxt = tail.p1y + hy_s[segi_pkg::CoordW-1:0];
      end else begin
        st_nxt = segi_pkg::ST_OUTSIDE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= tail.vld;
    end
    out_status    <= st_nxt;
    out_alpha_one <= a1_nxt;
    out_alpha_two <= a2_nxt;
    out_hit_x     <= hx_nxt;
    out_hit_y     <= hy_nxt;
  end

`ifndef NO_ASSERTIONS
  a_no_busy: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == segi_pkg::ST_PARALLEL |->
      out_alpha_one == '0 && out_alpha_two == '0 && out_hit_x == '0)
    else $error("parallel result not cleared");
  a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("bad status");
`endif

endmodule

// ===== rtl/core/segi_front.sv =====
// ----------------------------------------------------------------------------
// Segment intersection front end
// Forms differences and cross products over two registered stages and
// prepares the sign-magnitude dividends for the divider chain.
// ----------------------------------------------------------------------------
module segi_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  input  logic signed [segi_pkg::CoordW-1:0] p1x,
  input  logic signed [segi_pkg::CoordW-1:0] p1y,
  input  logic signed [segi_pkg::CoordW-1:0] q1x,
  input  logic signed [segi_pkg::CoordW-1:0] q1y,
  input  logic signed [segi_pkg::CoordW-1:0] p2x,
  input  logic signed [segi_pkg::CoordW-1:0] p2y,
  input  logic signed [segi_pkg::CoordW-1:0] q2x,
  input  logic signed [segi_pkg::CoordW-1:0] q2y,
  output segi_pkg::cell_bus_t                bus_out
);

  logic vld1_r, vld2_r;
  logic signed [segi_pkg::DiffW-1:0] d1x_r, d1y_r, d2x_r, d2y_r, ex_r, ey_r;
  logic signed [segi_pkg::CoordW-1:0] p1x_r, p1y_r, p1x2_r, p1y2_r;
  logic signed [segi_pkg::CrossW-1:0] den_r, n1_r, n2_r;
  logic signed [segi_pkg::DiffW-1:0] d1x2_r, d1y2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
    d1x_r  <= 17'(q1x) - 17'(p1x);
    d1y_r  <= 17'(q1y) - 17'(p1y);
    d2x_r  <= 17'(q2x) - 17'(p2x);
    d2y_r  <= 17'(q2y) - 17'(p2y);
    ex_r   <= 17'(p2x) - 17'(p1x);
    ey_r   <= 17'(p2y) - 17'(p1y);
    p1x_r  <= p1x;
    p1y_r  <= p1y;
    den_r  <= 35'(d1x_r * d2y_r) - 35'(d1y_r * d2x_r);
    n1_r   <= 35'(ex_r * d2y_r) - 35'(ey_r * d2x_r);
    n2_r   <= 35'(ex_r * d1y_r) - 35'(ey_r * d1x_r);
    d1x2_r <= d1x_r;
    d1y2_r <= d1y_r;
    p1x2_r <= p1x_r;
    p1y2_r <= p1y_r;
  end

  logic [segi_pkg::MagW-1:0] den_mag, n1_mag, n2_mag;
  logic signed [segi_pkg::CrossW-1:0] n1p, n2p;
  logic [segi_pkg::DiffW-2:0] d1x_mag, d1y_mag;
  logic [segi_pkg::HitMagW-1:0] hx_prod, hy_prod;

  always_comb begin
    den_mag = den_r[segi_pkg::CrossW-1] ? segi_pkg::MagW'(-den_r)
                                        : segi_pkg::MagW'(den_r);
    n1_mag  = n1_r[segi_pkg::CrossW-1] ? segi_pkg::MagW'(-n1_r) : segi_pkg::MagW'(n1_r);
    n2_mag  = n2_r[segi_pkg::CrossW-1] ? segi_pkg::MagW'(-n2_r) : segi_pkg::MagW'(n2_r);
    n1p     = den_r[segi_pkg::CrossW-1] ? -n1_r : n1_r;
    n2p     = den_r[segi_pkg::CrossW-1] ? -n2_r : n2_r;
    d1x_mag = d1x2_r[segi_pkg::DiffW-1] ? 16'(-d1x2_r) : 16'(d1x2_r);
    d1y_mag = d1y2_r[segi_pkg::DiffW-1] ? 16'(-d1y2_r) : 16'(d1y2_r);
    hx_prod = segi_pkg::HitMagW'({1'b0, d1x_mag} * {1'b0, n1_mag});
    hy_prod = segi_pkg::HitMagW'({1'b0, d1y_mag} * {1'b0, n1_mag});

    bus_out          = '0;
    bus_out.vld      = vld2_r;
    bus_out.den      = den_mag;
    bus_out.parallel = (den_r == '0);
    bus_out.hit_ok   = !n1p[segi_pkg::CrossW-1] && !n2p[segi_pkg::CrossW-1]
                       && (n1p <= $signed({1'b0, den_mag}))
                       && (n2p <= $signed({1'b0, den_mag}));
    bus_out.p1x      = p1x2_r;
    bus_out.p1y      = p1y2_r;
    bus_out.la1.dvd  = {1'b0, n1_mag, 16'h0000};
    bus_out.la1.neg  = n1_r[segi_pkg::CrossW-1] ^ den_r[segi_pkg::CrossW-1];
    bus_out.la2.dvd  = {1'b0, n2_mag, 16'h0000};
    bus_out.la2.neg  = n2_r[segi_pkg::CrossW-1] ^ den_r[segi_pkg::CrossW-1];
    bus_out.lhx.dvd  = hx_prod;
    bus_out.lhx.neg  = d1x2_r[segi_pkg::DiffW-1] ^ n1p[segi_pkg::CrossW-1];
    bus_out.lhy.dvd  = hy_prod;
    bus_out.lhy.neg  = d1y2_r[segi_pkg::DiffW-1] ^ n1p[segi_pkg::CrossW-1];
  end

endmodule

// ===== rtl/core/segi_cell.sv =====
// ----------------------------------------------------------------------------
// Segment intersection divider cell
// One restoring division step on each of four lanes, registered, passing
// the whole bundle to the next cell.
// ----------------------------------------------------------------------------
module segi_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  segi_pkg::cell_bus_t bus_in,
  output segi_pkg::cell_bus_t bus_out
);

  segi_pkg::cell_bus_t bus_r, bus_nxt;

  function automatic segi_pkg::div_lane_t step(input segi_pkg::div_lane_t l,
                                               input logic [segi_pkg::MagW-1:0] d);
    segi_pkg::div_lane_t o;
    logic [segi_pkg::RemW-1:0] t;
    begin
      o   = l;
      t   = {l.rem[segi_pkg::RemW-2:0], l.dvd[segi_pkg::QuotW-1]};
      o.dvd = {l.dvd[segi_pkg::QuotW-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        o.rem = t - {1'b0, d};
        o.quo = {l.quo[segi_pkg::QuotW-2:0], 1'b1};
      end else begin
        o.rem = t;
        o.quo = {l.quo[segi_pkg::QuotW-2:0], 1'b0};
      end
      step = o;
    end
  endfunction

  always_comb begin
    bus_nxt     = bus_in;
    bus_nxt.vld = bus_in.vld & rst_n;
    bus_nxt.la1 = step(bus_in.la1, bus_in.den);
    bus_nxt.la2 = step(bus_in.la2, bus_in.den);
    bus_nxt.lhx = step(bus_in.lhx, bus_in.den);
    bus_nxt.lhy = step(bus_in.lhy, bus_in.den);
  end

  always_ff @(posedge clk) begin
    bus_r <= bus_nxt;
  end

  assign bus_out = bus_r;

endmodule
